/* rtl/core/sas_pkg.sv */
// Shared types, codes and defaults of the sprite animation sequencer.
package sas_pkg;

	// Default sizes of the animation table and its fields.
	localparam int unsigned NUM_ANIMATIONS_DEF = 16;
	localparam int unsigned FRAME_BITS_DEF     = 12;
	localparam int unsigned DELAY_BITS_DEF     = 16;

	// Configuration port widths.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 7;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE    = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_ID_ZERO    = 3'd1;
	localparam logic [2:0] ST_NO_FRAMES  = 3'd2;
	localparam logic [2:0] ST_ZERO_DELAY = 3'd3;
	localparam logic [2:0] ST_OVERFLOW   = 3'd4;
	localparam logic [2:0] ST_DUPLICATE  = 3'd5;
	localparam logic [2:0] ST_UNKNOWN_ID = 3'd6;

	// Item commands.
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_PLAY   = 2'd1,
		CMD_DEFINE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// One input item as it arrives.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] elapsed_ticks;
		logic [3:0]  anim_id;
		logic [11:0] base_frame;
		logic [11:0] frame_count;
		logic [15:0] hold_ticks;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  status;
		logic        visible;
		logic [5:0]  sheet_column;
		logic [5:0]  sheet_row;
		logic [3:0]  shown_id;
		logic [11:0] shown_frame;
		logic        idling;
	} result_t;

	// A classified item as it waits between the front and the back.
	typedef struct packed {
		cmd_t        op;
		logic [15:0] elapsed_ticks;
		logic [3:0]  anim_id;
		logic [11:0] base_frame;
		logic [11:0] frame_count;
		logic [15:0] hold_ticks;
		logic        id_zero;
		logic        no_frames;
		logic        zero_delay;
		logic        start_zero;
		logic        id_beyond;
	} work_t;

	// One configuration write.
	typedef struct packed {
		logic                   en;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

endpackage

/* rtl/core/sas_fifo.sv */
// Small register queue used between the parts of the sequencer and at its output.
module sas_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage for queued entries.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/sas_front.sv */
// Front part: accepts items, decodes the command and checks the fixed define rules.
module sas_front #(
	parameter int unsigned NUM_ANIMATIONS = sas_pkg::NUM_ANIMATIONS_DEF,
	parameter int unsigned FRAME_BITS     = sas_pkg::FRAME_BITS_DEF,
	parameter int unsigned DELAY_BITS     = sas_pkg::DELAY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  sas_pkg::in_item_t item,
	input  logic             deq,
	output logic             avail,
	output sas_pkg::work_t   work
);
	import sas_pkg::*;

	localparam int unsigned CMP_W =
		(($clog2(NUM_ANIMATIONS) > 4) ? $clog2(NUM_ANIMATIONS) : 4) + 1;

	work_t                   work_d;
	logic [$bits(work_t)-1:0] work_bits;
	logic                    q_empty;

	// Classify the item before it is queued.
	always_comb begin
		work_d.op            = cmd_t'(item.cmd);
		work_d.elapsed_ticks = item.elapsed_ticks;
		work_d.anim_id       = item.anim_id;
		work_d.base_frame    = item.base_frame;
		work_d.frame_count   = item.frame_count;
		work_d.hold_ticks    = item.hold_ticks;
		work_d.id_zero       = (item.anim_id == '0);
		work_d.no_frames     = (FRAME_BITS'(item.frame_count) == '0);
		work_d.zero_delay    = (DELAY_BITS'(item.hold_ticks) == '0);
		work_d.start_zero    = (FRAME_BITS'(item.base_frame) == '0);
		work_d.id_beyond     = (CMP_W'(item.anim_id) >= CMP_W'(NUM_ANIMATIONS));
	end

	sas_fifo #(
		.WIDTH($bits(work_t)),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (work_d),
		.pop   (deq),
		.empty (q_empty),
		.rdata (work_bits)
	);

	assign avail = !q_empty;
	assign work  = work_t'(work_bits);

endmodule

/* rtl/core/sas_back.sv */
// Back part: animation table, frame advance loop, row and column divider, result queue.
module sas_back #(
	parameter int unsigned NUM_ANIMATIONS = sas_pkg::NUM_ANIMATIONS_DEF,
	parameter int unsigned FRAME_BITS     = sas_pkg::FRAME_BITS_DEF,
	parameter int unsigned DELAY_BITS     = sas_pkg::DELAY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sas_pkg::cfg_wr_t cfg,
	input  logic             avail,
	output logic             deq,
	input  sas_pkg::work_t   work,
	output logic             empty,
	input  logic             pop,
	output sas_pkg::result_t result
);
	import sas_pkg::*;

	localparam int unsigned IW    = (NUM_ANIMATIONS > 1) ? $clog2(NUM_ANIMATIONS) : 1;
	localparam int unsigned CW    = ((IW > 4) ? IW : 4) + 1;
	localparam int unsigned AW    = ((DELAY_BITS > 17) ? DELAY_BITS : 17) + 1;
	localparam int unsigned PW    = FRAME_BITS + 1;
	localparam int unsigned CNW   = $clog2(PW);
	localparam int unsigned XW    = ((PW > 14) ? PW : 14) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD,
		S_STEP,
		S_POS,
		S_DIV
	} state_t;

	// Animation table memory.
	logic [FRAME_BITS-1:0] mem_start [NUM_ANIMATIONS];
	logic [FRAME_BITS-1:0] mem_count [NUM_ANIMATIONS];
	logic [DELAY_BITS-1:0] mem_delay [NUM_ANIMATIONS];
	logic [FRAME_BITS-1:0] rd_start_q;
	logic [FRAME_BITS-1:0] rd_count_q;
	logic [DELAY_BITS-1:0] rd_delay_q;

	state_t                state_q;
	work_t                 work_q;
	logic [NUM_ANIMATIONS-1:0] valid_q;
	logic [AW-1:0]         accum_q;
	logic [3:0]            cur_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic                  idle_q;
	logic [6:0]            cols_q;
	logic [6:0]            rows_q;
	logic                  repeat_q;
	logic [3:0]            idle_id_q;
	logic [13:0]           total_q;
	logic [2:0]            status_q;
	logic                  tick_q;
	logic [PW-1:0]         pos_q;
	logic [5:0]            rem_q;
	logic [CNW-1:0]        cnt_q;

	logic [13:0]           prod;
	logic [IW-1:0]         cur_idx;
	logic [IW-1:0]         wk_idx;
	logic [FRAME_BITS-1:0] start_m;
	logic [FRAME_BITS-1:0] count_m;
	logic [DELAY_BITS-1:0] delay_m;
	logic [2:0]            def_status;
	logic [2:0]            play_status;
	logic                  mem_we;
	logic                  idle_ok;
	logic [3:0]            idle_new;
	logic [AW-1:0]         delay_x;
	logic [FRAME_BITS-1:0] frame_inc;
	logic [6:0]            rem_sh;
	logic                  ge;
	logic [5:0]            rem_nx;
	logic [PW-1:0]         quot_nx;
	logic                  out_push;
	logic                  out_full;
	result_t               res_d;
	logic [$bits(result_t)-1:0] res_bits;
	logic [3:0]            cfg_idle;
	logic                  cfg_idle_ok;

	function automatic logic in_range(input logic [3:0] id);
		in_range = (CW'(id) < CW'(NUM_ANIMATIONS));
	endfunction

	function automatic logic [6:0] clamp_dim(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (v == 7'd0) begin
			r = 7'd1;
		end else if (v > 7'd64) begin
			r = 7'd64;
		end
		clamp_dim = r;
	endfunction

	assign prod      = {7'd0, cols_q} * {7'd0, rows_q};
	assign cur_idx   = IW'(cur_q);
	assign wk_idx    = IW'(work_q.anim_id);
	assign start_m   = FRAME_BITS'(work_q.base_frame);
	assign count_m   = FRAME_BITS'(work_q.frame_count);
	assign delay_m   = DELAY_BITS'(work_q.hold_ticks);
	assign idle_ok   = (idle_id_q != '0) && in_range(idle_id_q) && valid_q[IW'(idle_id_q)];
	assign idle_new  = idle_ok ? idle_id_q : 4'd0;
	assign delay_x   = AW'(rd_delay_q);
	assign frame_inc = frame_q + 1'b1;
	assign cfg_idle  = cfg.data[3:0];
	assign cfg_idle_ok = (cfg_idle != '0) && in_range(cfg_idle) && valid_q[IW'(cfg_idle)];

	// Define checks in priority order.
	always_comb begin
		def_status = ST_OK;
		if (work_q.id_zero) begin
			def_status = ST_ID_ZERO;
		end else if (work_q.no_frames) begin
			def_status = ST_NO_FRAMES;
		end else if (work_q.zero_delay) begin
			def_status = ST_ZERO_DELAY;
		end else if (work_q.start_zero ||
				(XW'(start_m) + XW'(count_m) > XW'(total_q) + XW'(1))) begin
			def_status = ST_OVERFLOW;
		end else if (work_q.id_beyond) begin
			def_status = ST_UNKNOWN_ID;
		end else if (valid_q[wk_idx]) begin
			def_status = ST_DUPLICATE;
		end
	end

	// A play of another animation needs a defined entry.
	always_comb begin
		play_status = ST_OK;
		if (work_q.anim_id != cur_q) begin
			if (work_q.id_zero || work_q.id_beyond || !valid_q[wk_idx]) begin
				play_status = ST_UNKNOWN_ID;
			end
		end
	end

	assign mem_we = (state_q == S_EXEC) && (work_q.op == CMD_DEFINE) && (def_status == ST_OK);

	// Table writes and the registered read of the current entry.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_start[wk_idx] <= start_m;
			mem_count[wk_idx] <= count_m;
			mem_delay[wk_idx] <= delay_m;
		end
		rd_start_q <= mem_start[cur_idx];
		rd_count_q <= mem_count[cur_idx];
		rd_delay_q <= mem_delay[cur_idx];
	end

	// One restoring divider step: sheet position over the column count.
	assign rem_sh  = {rem_q, pos_q[PW-1]};
	assign ge      = (rem_sh >= cols_q);
	assign rem_nx  = 6'(ge ? rem_sh - cols_q : rem_sh);
	assign quot_nx = {pos_q[PW-2:0], ge};

	assign deq      = (state_q == S_IDLE) && avail && !out_full;
	assign out_push = (state_q == S_DIV) && (cnt_q == '0);

	// Result fields of the shown frame.
	always_comb begin
		res_d.status  = status_q;
		res_d.visible = (cur_q != '0);
		res_d.idling  = idle_q;
		if (cur_q != '0) begin
			res_d.sheet_column = rem_nx;
			res_d.sheet_row    = quot_nx[5:0];
			res_d.shown_id     = cur_q;
			res_d.shown_frame  = 12'(frame_q);
		end else begin
			res_d.sheet_column = '0;
			res_d.sheet_row    = '0;
			res_d.shown_id     = '0;
			res_d.shown_frame  = '0;
		end
	end

	// Sequencer state, animation state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			accum_q   <= '0;
			cur_q     <= '0;
			frame_q   <= '0;
			idle_q    <= 1'b1;
			cols_q    <= 7'd1;
			rows_q    <= 7'd1;
			repeat_q  <= 1'b0;
			idle_id_q <= '0;
			total_q   <= 14'd1;
			status_q  <= ST_OK;
			tick_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			total_q <= prod;
			unique case (state_q)
				S_IDLE: begin
					if (deq) begin
						work_q  <= work;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q  <= S_LOAD;
					tick_q   <= 1'b0;
					status_q <= ST_OK;
					unique case (work_q.op)
						CMD_TICK: begin
							if (cur_q != '0) begin
								accum_q <= accum_q + AW'(work_q.elapsed_ticks);
								tick_q  <= 1'b1;
							end
						end
						CMD_PLAY: begin
							status_q <= play_status;
							if (play_status == ST_OK) begin
								cur_q   <= work_q.anim_id;
								frame_q <= '0;
								accum_q <= '0;
								idle_q  <= 1'b0;
							end
						end
						CMD_DEFINE: begin
							status_q <= def_status;
							if (def_status == ST_OK) begin
								valid_q[wk_idx] <= 1'b1;
							end
						end
						CMD_NOP: ;
						default: ;
					endcase
				end
				S_LOAD: begin
					state_q <= tick_q ? S_STEP : S_POS;
				end
				S_STEP: begin
					// Move one frame while the stored time covers a whole delay.
					if (cur_q == '0 || accum_q < delay_x) begin
						state_q <= S_POS;
					end else begin
						accum_q <= accum_q - delay_x;
						if (frame_inc >= rd_count_q) begin
							frame_q <= '0;
							if (!repeat_q) begin
								idle_q <= 1'b1;
								cur_q  <= idle_new;
								if (idle_new != cur_q) begin
									state_q <= S_LOAD;
								end
							end
						end else begin
							frame_q <= frame_inc;
						end
					end
				end
				S_POS: begin
					pos_q   <= (cur_q != '0) ?
						PW'(rd_start_q) + PW'(frame_q) - PW'(1) : '0;
					rem_q   <= '0;
					cnt_q   <= CNW'(PW - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= rem_nx;
					pos_q <= quot_nx;
					if (cnt_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// Configuration writes must arrive only while no item is in flight; the block itself does not enforce it.
			if (cfg.en) begin
				case (cfg.index)
					REG_COLUMNS: begin
						cols_q  <= clamp_dim(cfg.data);
						valid_q <= '0;
						cur_q   <= '0;
					end
					REG_ROWS: begin
						rows_q  <= clamp_dim(cfg.data);
						valid_q <= '0;
						cur_q   <= '0;
					end
					REG_REPEAT: repeat_q <= cfg.data[0];
					REG_IDLE: begin
						if (cfg_idle != idle_id_q) begin
							idle_id_q <= cfg_idle;
							if (idle_q) begin
								cur_q   <= cfg_idle_ok ? cfg_idle : 4'd0;
								frame_q <= '0;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	sas_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(2)
	) u_result_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.full  (out_full),
		.wdata (res_d),
		.pop   (pop),
		.empty (empty),
		.rdata (res_bits)
	);

	assign result = result_t'(res_bits);

	// A nonzero current animation always names a defined table entry.
	a_cur_defined: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q != '0) |-> (in_range(cur_q) && valid_q[cur_idx]))
		else $error("current animation is not a defined entry");

	// A result is only produced when the result queue has room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result transfer into a full queue");

	// After the frame advance loop the stored time is below one frame delay.
	a_accum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POS && tick_q && cur_q != '0) |-> (accum_q < delay_x))
		else $error("frame advance ended with a whole delay left");

	// An accepted item reaches execution in the next cycle.
	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		deq |=> (state_q == S_EXEC))
		else $error("accepted item did not start execution");

endmodule

/* rtl/core/sprite_animation_sequencer.sv */
// Top level of the sprite animation sequencer: front decoder, back executor, port wiring.
//
// Plays animations from a sprite sheet: define items store an entry (first frame, frame count,
// frame delay) in a 16-entry table, play items start one, tick items add elapsed ticks and move
// on as many frames as that time covers, falling back to the idle animation or restarting at the
// end. Every item gives one result with the status and the sheet row and column of the shown
// frame. Items enter through a two-entry queue and results leave through another, so each side
// may stall on its own. The back handles one item at a time and finds the sheet row and column
// with a one-bit-per-cycle divider. A tick while an animation is shown also runs the frame
// advance loop, which moves one frame per step and reloads the table entry each time the current
// animation changes at the end of a run.
// Writing the sheet columns or rows clears the table.
module sprite_animation_sequencer #(
	parameter int unsigned NUM_ANIMATIONS = sas_pkg::NUM_ANIMATIONS_DEF,
	parameter int unsigned FRAME_BITS     = sas_pkg::FRAME_BITS_DEF,
	parameter int unsigned DELAY_BITS     = sas_pkg::DELAY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  sas_pkg::in_item_t              item,
	output logic                           empty,
	input  logic                           pop,
	output sas_pkg::result_t               result,
	input  logic                           wr_en,
	input  logic [sas_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [sas_pkg::CFG_DATA_W-1:0]  wr_data
);
	import sas_pkg::*;

	cfg_wr_t cfg;
	work_t   work;
	logic    avail;
	logic    deq;

	assign cfg.en    = wr_en;
	assign cfg.index = wr_index;
	assign cfg.data  = wr_data;

	sas_front #(
		.NUM_ANIMATIONS(NUM_ANIMATIONS),
		.FRAME_BITS    (FRAME_BITS),
		.DELAY_BITS    (DELAY_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.deq   (deq),
		.avail (avail),
		.work  (work)
	);

	sas_back #(
		.NUM_ANIMATIONS(NUM_ANIMATIONS),
		.FRAME_BITS    (FRAME_BITS),
		.DELAY_BITS    (DELAY_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.avail (avail),
		.deq   (deq),
		.work  (work),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

endmodule

/* bench/tb_sprite_animation_sequencer.sv */
// Self-checking testbench for the sprite animation sequencer: predictor scoreboard and drivers.
`timescale 1ns / 1ps

module tb_sprite_animation_sequencer;
	import sas_pkg::*;

	localparam int unsigned NUM_IDS     = 16;
	localparam longint     CYCLE_LIMIT = 3_000_000;

	// Predicts one result per transfer in and checks results in order.
	class anim_scoreboard;
		bit          valid[NUM_IDS];
		bit [11:0]   first_frame[NUM_IDS];
		bit [11:0]   frame_total[NUM_IDS];
		bit [15:0]   delay[NUM_IDS];
		longint unsigned accum;
		bit [3:0]    cur_id;
		int unsigned frame_idx;
		bit          idle_f;
		int unsigned cols;
		int unsigned rows;
		bit          repeat_on;
		bit [3:0]    idle_anim;
		result_t     expected_q[$];
		int          errors;

		function new();
			cols = 1;
			rows = 1;
			repeat_on = 0;
			idle_anim = 0;
			clear_table();
			accum = 0;
			frame_idx = 0;
			idle_f = 1;
			errors = 0;
		endfunction

		function bit entry_ok(bit [3:0] id);
			return id != 0 && valid[id];
		endfunction

		function void clear_table();
			foreach (valid[i]) begin
				valid[i] = 0;
				first_frame[i] = 0;
				frame_total[i] = 0;
				delay[i] = 0;
			end
			cur_id = 0;
		endfunction

		function void go_idle();
			idle_f = 1;
			cur_id = entry_ok(idle_anim) ? idle_anim : 4'd0;
			frame_idx = 0;
		endfunction

		function int unsigned clamp_dim(bit [6:0] v);
			if (v < 1) return 1;
			if (v > 64) return 64;
			return v;
		endfunction

		function bit [15:0] cur_delay();
			return entry_ok(cur_id) ? delay[cur_id] : 16'd0;
		endfunction

		// Mirrors the effect of one register write.
		function void write_reg(bit [CFG_INDEX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
			case (idx)
				REG_COLUMNS: begin
					cols = clamp_dim(data);
					clear_table();
				end
				REG_ROWS: begin
					rows = clamp_dim(data);
					clear_table();
				end
				REG_REPEAT: repeat_on = data[0];
				REG_IDLE: begin
					if (data[3:0] != idle_anim) begin
						idle_anim = data[3:0];
						if (idle_f)
							go_idle();
					end
				end
			endcase
		endfunction

		function bit [2:0] define_entry(in_item_t it);
			int unsigned total;
			total = cols * rows;
			if (it.anim_id == 0) return ST_ID_ZERO;
			if (it.frame_count == 0) return ST_NO_FRAMES;
			if (it.hold_ticks == 0) return ST_ZERO_DELAY;
			if (it.base_frame == 0 || it.base_frame + it.frame_count - 1 > total)
				return ST_OVERFLOW;
			if (valid[it.anim_id]) return ST_DUPLICATE;
			valid[it.anim_id] = 1;
			first_frame[it.anim_id] = it.base_frame;
			frame_total[it.anim_id] = it.frame_count;
			delay[it.anim_id] = it.hold_ticks;
			return ST_OK;
		endfunction

		function bit [2:0] play_entry(in_item_t it);
			if (it.anim_id != cur_id) begin
				if (!entry_ok(it.anim_id)) return ST_UNKNOWN_ID;
				cur_id = it.anim_id;
			end
			frame_idx = 0;
			accum = 0;
			idle_f = 0;
			return ST_OK;
		endfunction

		function void advance(in_item_t it);
			if (cur_id == 0) return;
			accum += it.elapsed_ticks;
			while (cur_id != 0 && accum >= delay[cur_id]) begin
				accum -= delay[cur_id];
				frame_idx++;
				if (frame_idx >= frame_total[cur_id]) begin
					if (repeat_on) frame_idx = 0;
					else go_idle();
				end
			end
		endfunction

		// Updates the predicted state and queues the expected result.
		function void note_input(in_item_t it);
			result_t r;
			int unsigned pos;
			r = '0;
			case (cmd_t'(it.cmd))
				CMD_TICK:   advance(it);
				CMD_PLAY:   r.status = play_entry(it);
				CMD_DEFINE: r.status = define_entry(it);
				default:    r.status = ST_OK;
			endcase
			if (entry_ok(cur_id)) begin
				pos = first_frame[cur_id] + frame_idx - 1;
				r.visible = 1;
				r.sheet_column = 6'(pos % cols);
				r.sheet_row = 6'(pos / cols);
				r.shown_id = cur_id;
				r.shown_frame = 12'(frame_idx);
			end
			r.idling = idle_f;
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing expected", 1, 0);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.visible !== want.visible)
				report_mismatch("visible", got.visible, want.visible);
			if (got.sheet_column !== want.sheet_column)
				report_mismatch("sheet_column", got.sheet_column, want.sheet_column);
			if (got.sheet_row !== want.sheet_row)
				report_mismatch("sheet_row", got.sheet_row, want.sheet_row);
			if (got.shown_id !== want.shown_id)
				report_mismatch("shown_id", got.shown_id, want.shown_id);
			if (got.shown_frame !== want.shown_frame)
				report_mismatch("shown_frame", got.shown_frame, want.shown_frame);
			if (got.idling !== want.idling)
				report_mismatch("idling", got.idling, want.idling);
		endtask
	endclass

	logic                   clk = 0;
	logic                   arst_n = 0;
	logic                   push = 0;
	logic                   full;
	in_item_t               item = '0;
	logic                   empty;
	logic                   pop = 0;
	result_t                result;
	logic                   wr_en = 0;
	logic [CFG_INDEX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0]  wr_data = '0;

	anim_scoreboard sb = new();
	longint         cycles = 0;
	int             burst_left = 0;
	int unsigned    rx_count = 0;

	sprite_animation_sequencer dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #2 clk = ~clk;

	// Cycle counter with the run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** sprite_animation_sequencer: FAILED **");
			$finish;
		end
	end

	// Result side: check each transfer, then pick the next pop from a shifting stall pattern.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result(result);
			rx_count++;
			case ((rx_count / 97) % 4)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 1);
				2: pop <= ($urandom_range(0, 7) == 0);
				default: pop <= (rx_count % 16) >= 4;
			endcase
		end
	end

	function automatic in_item_t mk(cmd_t c, int el, int id, int st, int cnt, int dl);
		in_item_t it;
		it.cmd = c;
		it.elapsed_ticks = 16'(el);
		it.anim_id = 4'(id);
		it.base_frame = 12'(st);
		it.frame_count = 12'(cnt);
		it.hold_ticks = 16'(dl);
		return it;
	endfunction

	// Sends one item in bursts with random gaps; notes it when the transfer happens.
	task send(in_item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		sb.note_input(it);
		burst_left--;
	endtask

	// Stops sending and waits until every expected result has come.
	task drain();
		push <= 1'b0;
		burst_left = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Writes a register; the caller lowers wr_en after the last write.
	task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task configure(int c, int r, int rep, int idle);
		write_reg(REG_COLUMNS, 7'(c));
		write_reg(REG_ROWS, 7'(r));
		write_reg(REG_REPEAT, 7'(rep));
		write_reg(REG_IDLE, 7'(idle));
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Random item: mostly well-formed defines, plays of defined ids and ticks.
	function automatic in_item_t random_item();
		in_item_t it;
		int unsigned total, st, cnt, pick;
		longint lim;
		it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
		pick = $urandom_range(0, 99);
		total = sb.cols * sb.rows;
		if (pick < 12) begin
			it.cmd = CMD_DEFINE;
			it.anim_id = 4'($urandom_range(1, 15));
			st = $urandom_range(1, total > 4095 ? 4095 : total);
			cnt = $urandom_range(1, total - st + 1 > 4095 ? 4095 : total - st + 1);
			it.base_frame = 12'(st);
			it.frame_count = 12'(cnt);
			case ($urandom_range(0, 9))
				0: it.hold_ticks = 16'($urandom_range(1, 65535));
				1, 2, 3, 4: it.hold_ticks = 16'($urandom_range(1, 2000));
				default: it.hold_ticks = 16'($urandom_range(1, 16));
			endcase
		end else if (pick < 16) begin
			it.cmd = CMD_DEFINE;
		end else if (pick < 30) begin
			it.cmd = CMD_PLAY;
			it.anim_id = 4'($urandom_range(1, 15));
			if (!sb.valid[it.anim_id])
				it.anim_id = sb.cur_id;
		end else if (pick < 34) begin
			it.cmd = CMD_PLAY;
		end else if (pick < 37) begin
			it.cmd = CMD_NOP;
		end else begin
			it.cmd = CMD_TICK;
			lim = sb.cur_delay() == 0 ? 300 : longint'(sb.cur_delay()) * 6 + 50;
			if (lim > 65535)
				lim = 65535;
			it.elapsed_ticks = 16'($urandom_range(0, int'(lim)));
		end
		return it;
	endfunction

	int cfg_cols[7] = '{0, 5, 64, 1, 13, 2, 7};
	int cfg_rows[7] = '{127, 3, 1, 64, 9, 2, 11};
	int cfg_rep[7]  = '{0, 1, 0, 1, 0, 0, 1};
	int cfg_idle[7] = '{3, 2, 15, 7, 1, 4, 0};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on an 8 x 4 sheet: the checks of a define, plays and ticks.
		configure(8, 4, 0, 0);
		send(mk(CMD_TICK, 5, 0, 0, 0, 0));
		send(mk(CMD_PLAY, 0, 0, 0, 0, 0));
		send(mk(CMD_DEFINE, 0, 0, 1, 1, 1));
		send(mk(CMD_DEFINE, 0, 3, 1, 0, 1));
		send(mk(CMD_DEFINE, 0, 3, 1, 1, 0));
		send(mk(CMD_DEFINE, 0, 3, 0, 1, 1));
		send(mk(CMD_DEFINE, 0, 3, 30, 4, 1));
		send(mk(CMD_DEFINE, 0, 1, 1, 4, 3));
		send(mk(CMD_DEFINE, 0, 1, 2, 2, 2));
		send(mk(CMD_PLAY, 0, 9, 0, 0, 0));
		send(mk(CMD_PLAY, 0, 1, 0, 0, 0));
		send(mk(CMD_TICK, 2, 0, 0, 0, 0));
		send(mk(CMD_TICK, 7, 0, 0, 0, 0));
		send(mk(CMD_NOP, 0, 0, 0, 0, 0));
		send(mk(CMD_DEFINE, 0, 2, 29, 4, 65535));
		send(mk(CMD_PLAY, 0, 2, 0, 0, 0));
		send(mk(CMD_TICK, 65535, 0, 0, 0, 0));
		send(mk(CMD_PLAY, 0, 1, 0, 0, 0));
		send(mk(CMD_PLAY, 0, 1, 0, 0, 0));
		send(mk(CMD_PLAY, 0, 0, 0, 0, 0));
		send(mk(CMD_TICK, 40, 0, 0, 0, 0));
		drain();

		// Directed part on the largest sheet: widest frame fields and a long frame run.
		configure(64, 64, 1, 0);
		send(mk(CMD_DEFINE, 0, 15, 4095, 1, 65535));
		send(mk(CMD_DEFINE, 0, 14, 1, 4095, 1));
		send(mk(CMD_PLAY, 0, 15, 0, 0, 0));
		send(mk(CMD_TICK, 65535, 0, 0, 0, 0));
		send(mk(CMD_PLAY, 0, 14, 0, 0, 0));
		send(mk(CMD_TICK, 65535, 0, 0, 0, 0));
		drain();

		// Random phases, each with its own sheet, mode and idle animation.
		for (int p = 0; p < 7; p++) begin
			configure(cfg_cols[p], cfg_rows[p], cfg_rep[p], cfg_idle[p]);
			for (int n = 0; n < 190; n++) begin
				if (n == 95) begin
					// Pause until all results are in, then change mode and idle animation.
					drain();
					write_reg(REG_IDLE, 7'($urandom_range(0, 127)));
					write_reg(REG_REPEAT, 7'($urandom_range(0, 127)));
					wr_en <= 1'b0;
					@(posedge clk);
				end
				send(random_item());
			end
			drain();
		end

		if (sb.expected_q.size() != 0)
			sb.report_mismatch("results never delivered", 0, sb.expected_q.size());
		if (sb.errors == 0)
			$display("** sprite_animation_sequencer: PASSED **");
		else
			$display("** sprite_animation_sequencer: FAILED **");
		$finish;
	end

endmodule
